// ----- hdl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and helper functions of the bitset scan unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned WordIdxW  = 6;
  localparam int unsigned WordPosW  = 5;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned IndexW    = 10;

  localparam logic signed [1:0] OrderNone  = 2'sb00;
  localparam logic signed [1:0] OrderAHigh = 2'sb01;
  localparam logic signed [1:0] OrderBHigh = 2'sb11;

  // one classified word pair, front to back
  typedef struct packed {
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    logic [WordBits-1:0] cand;
    logic [WordPosW-1:0] pos;
    logic                first;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [WordBits-1:0] hash_a;
    logic [SizeW-1:0]    count_a;
    logic                sets_equal;
    logic signed [1:0]   order;
    logic                found;
    logic [IndexW-1:0]   found_index;
  } result_t;

  // pairwise adder tree, six levels deep
  function automatic logic [WordIdxW:0] ones_in(input logic [WordBits-1:0] v);
    logic [WordIdxW:0] s [WordBits];
    for (int i = 0; i < WordBits; i++) begin
      s[i] = {{WordIdxW{1'b0}}, v[i]};
    end
    for (int w = WordBits >> 1; w >= 1; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction

  function automatic logic [WordIdxW-1:0] lowest_one(input logic [WordBits-1:0] v);
    logic [WordIdxW-1:0] k;
    k = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = WordIdxW'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- hdl/bsc_fifo.sv -----
// ----------------------------------------------------------------------------
// bsc_fifo
// Small register-based queue with full/empty flags.
// ----------------------------------------------------------------------------
module bsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill not tracking transfer");

endmodule

// ----- hdl/bsc_front.sv -----
// ----------------------------------------------------------------------------
// bsc_front
// Takes word pairs, masks tail bits, marks first/last word and builds the
// search candidate word.
// ----------------------------------------------------------------------------
module bsc_front #(
  parameter int unsigned MAX_BITS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           set_bits_we_i,
  input  logic [bsc_pkg::SizeW-1:0]      set_bits_i,
  input  logic                           push_i,
  input  logic [bsc_pkg::WordBits-1:0]   word_a_i,
  input  logic [bsc_pkg::WordBits-1:0]   word_b_i,
  input  logic [bsc_pkg::SizeW-1:0]      search_from_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output bsc_pkg::item_t                 q_item_o
);

  localparam logic [16:0] MaxBitsW = 17'(MAX_BITS);

  logic [bsc_pkg::SizeW-1:0]    set_bits_q, size, base, rem, ss, off;
  logic [bsc_pkg::SizeW-1:0]    ss_q;
  logic [bsc_pkg::SizeW:0]      base_end;
  logic [bsc_pkg::WordPosW-1:0] pos_q, pos_d;
  logic [bsc_pkg::WordBits-1:0] mask, a;
  logic                         first, last, accept;

  assign accept = push_i & ~q_full_i;
  assign first  = (pos_q == '0);

  always_comb begin
    if (set_bits_q == '0) begin
      size = bsc_pkg::SizeW'(1);
    end else if ({6'd0, set_bits_q} > MaxBitsW) begin
      size = MaxBitsW[bsc_pkg::SizeW-1:0];
    end else begin
      size = set_bits_q;
    end

    base     = {pos_q, {bsc_pkg::WordIdxW{1'b0}}};
    base_end = {1'b0, base} + (bsc_pkg::SizeW + 1)'(bsc_pkg::WordBits);
    rem      = size - base;
    last     = (base_end >= {1'b0, size});

    if (base >= size) begin
      mask = '0;
    end else if (rem >= bsc_pkg::SizeW'(bsc_pkg::WordBits)) begin
      mask = '1;
    end else begin
      mask = ({{(bsc_pkg::WordBits-1){1'b0}}, 1'b1} << rem[bsc_pkg::WordIdxW-1:0])
             - {{(bsc_pkg::WordBits-1){1'b0}}, 1'b1};
    end

    a   = word_a_i & mask;
    ss  = first ? search_from_i : ss_q;
    off = ss - base;

    q_item_o.a     = a;
    q_item_o.b     = word_b_i & mask;
    q_item_o.pos   = pos_q;
    q_item_o.first = first;
    q_item_o.last  = last;
    if ({1'b0, ss} >= base_end) begin
      q_item_o.cand = '0;
    end else if (ss > base) begin
      q_item_o.cand = a & ({bsc_pkg::WordBits{1'b1}} << off[bsc_pkg::WordIdxW-1:0]);
    end else begin
      q_item_o.cand = a;
    end

    pos_d = last ? '0 : pos_q + 1'b1;
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= bsc_pkg::SizeW'(64);
      pos_q      <= '0;
      ss_q       <= '0;
    end else begin
      if (set_bits_we_i) begin
        set_bits_q <= set_bits_i;
      end
      if (accept) begin
        pos_q <= pos_d;
        if (first) begin
          ss_q <= search_from_i;
        end
      end
    end
  end

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (pos_q == '0))
    else $error("word position not cleared after final word");

endmodule

// ----- hdl/bsc_back.sv -----
// ----------------------------------------------------------------------------
// bsc_back
// Accumulates hash, popcount, order and first hit over the words of a set
// and emits one result on the final word.
// ----------------------------------------------------------------------------
module bsc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  bsc_pkg::item_t    q_item_i,
  output logic              q_pop_o,
  input  logic              r_full_i,
  output logic              r_push_o,
  output bsc_pkg::result_t  r_data_o
);

  logic [bsc_pkg::WordBits-1:0] hash_q, hash_d, diff, low;
  logic [bsc_pkg::SizeW-1:0]    count_q, count_d;
  logic                         dec_q, dec_d, seen_q, seen_d;
  logic signed [1:0]            order_q, order_d;
  logic [bsc_pkg::SizeW-1:0]    hit_q, hit_d;
  logic                         take;

  assign take     = ~q_empty_i & ~r_full_i;
  assign q_pop_o  = take;
  assign r_push_o = take & q_item_i.last;

  always_comb begin
    hash_d  = q_item_i.first ? '0 : hash_q;
    count_d = q_item_i.first ? '0 : count_q;
    dec_d   = q_item_i.first ? 1'b0 : dec_q;
    order_d = q_item_i.first ? bsc_pkg::OrderNone : order_q;
    seen_d  = q_item_i.first ? 1'b0 : seen_q;
    hit_d   = q_item_i.first ? '0 : hit_q;

    hash_d  = hash_d + q_item_i.a;
    count_d = count_d + {4'd0, bsc_pkg::ones_in(q_item_i.a)};

    diff = q_item_i.a ^ q_item_i.b;
    low  = diff & (~diff + 1'b1);
    if (!dec_d && (diff != '0)) begin
      dec_d   = 1'b1;
      order_d = ((q_item_i.a & low) != '0) ? bsc_pkg::OrderAHigh : bsc_pkg::OrderBHigh;
    end

    if (!seen_d && (q_item_i.cand != '0)) begin
      seen_d = 1'b1;
      hit_d  = {q_item_i.pos, bsc_pkg::lowest_one(q_item_i.cand)};
    end

    r_data_o.hash_a      = hash_d;
    r_data_o.count_a     = count_d;
    r_data_o.sets_equal  = ~dec_d;
    r_data_o.order       = order_d;
    r_data_o.found       = seen_d;
    r_data_o.found_index = seen_d ? hit_d[bsc_pkg::IndexW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      count_q <= '0;
      dec_q   <= 1'b0;
      order_q <= bsc_pkg::OrderNone;
      seen_q  <= 1'b0;
      hit_q   <= '0;
    end else if (take) begin
      hash_q  <= hash_d;
      count_q <= count_d;
      dec_q   <= dec_d;
      order_q <= order_d;
      seen_q  <= seen_d;
      hit_q   <= hit_d;
    end
  end

  a_equal_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_push_o |-> (r_data_o.sets_equal == (r_data_o.order == bsc_pkg::OrderNone)))
    else $error("equality flag disagrees with order");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_push_o && !r_data_o.found) |-> (r_data_o.found_index == '0))
    else $error("index set without a hit");

endmodule

// ----- hdl/bitset_scan_compare_unit.sv -----
// ----------------------------------------------------------------------------
// bitset_scan_compare_unit
// Streams two bitsets word by word and reports hash, popcount, equality,
// order and the first set bit of A at or above a search start.
// ----------------------------------------------------------------------------
// Input queue: one transfer per word pair (word_a_i, word_b_i, search_from_i)
// when push is high and full is low, lowest word first; search_from_i counts
// only on the first word of a set. ceil(size / 64) words make a set, size
// being set_bits clamped to 1..MAX_BITS.
// Result queue: after the final word of a set one result waits on the
// result ports while empty is low and leaves on a transfer with pop high.
// Throughput: one word pair per cycle while full is low. The front masks
// and classifies the word and hands it to a two-entry queue; the back stage
// does popcount, lowest-bit search and the 64-bit add combinationally. A
// result enters the result queue as its final word leaves the inner queue.
// set_bits is written with set_bits_we_i; reset value is 64. Reset empties
// both queues and restarts the word count.
// When the receiver stalls the result queue (two entries) fills, the back
// stage stops, the inner queue fills and full rises; no item is dropped.
// ----------------------------------------------------------------------------
module bitset_scan_compare_unit #(
  parameter int unsigned MAX_BITS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          set_bits_we_i,
  input  logic [bsc_pkg::SizeW-1:0]     set_bits_i,
  input  logic                          push,
  output logic                          full,
  input  logic [bsc_pkg::WordBits-1:0]  word_a_i,
  input  logic [bsc_pkg::WordBits-1:0]  word_b_i,
  input  logic [bsc_pkg::SizeW-1:0]     search_from_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [bsc_pkg::WordBits-1:0]  hash_a_o,
  output logic [bsc_pkg::SizeW-1:0]     count_a_o,
  output logic                          sets_equal_o,
  output logic signed [1:0]             order_o,
  output logic                          found_o,
  output logic [bsc_pkg::IndexW-1:0]    found_index_o
);

  localparam int unsigned ItemW = $bits(bsc_pkg::item_t);
  localparam int unsigned ResW  = $bits(bsc_pkg::result_t);

  logic             mid_push, mid_pop, mid_empty, res_push, res_full;
  bsc_pkg::item_t   front_item, back_item;
  bsc_pkg::result_t back_res, out_res;
  logic [ItemW-1:0] mid_rdata;
  logic [ResW-1:0]  res_rdata;

  bsc_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_bits_we_i (set_bits_we_i),
    .set_bits_i    (set_bits_i),
    .push_i        (push),
    .word_a_i      (word_a_i),
    .word_b_i      (word_b_i),
    .search_from_i (search_from_i),
    .q_full_i      (full),
    .q_push_o      (mid_push),
    .q_item_o      (front_item)
  );

  bsc_fifo #(
    .WIDTH (ItemW),
    .DEPTH (2)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign back_item = mid_rdata;

  bsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (mid_empty),
    .q_item_i  (back_item),
    .q_pop_o   (mid_pop),
    .r_full_i  (res_full),
    .r_push_o  (res_push),
    .r_data_o  (back_res)
  );

  bsc_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_res       = res_rdata;
  assign hash_a_o      = out_res.hash_a;
  assign count_a_o     = out_res.count_a;
  assign sets_equal_o  = out_res.sets_equal;
  assign order_o       = out_res.order;
  assign found_o       = out_res.found;
  assign found_index_o = out_res.found_index;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitset_scan_compare_unit. Word pairs are queued
// by a stimulus process and offered by a clocked driver. Each transfer
// folds into a local scan model that predicts the per-set result. A clocked
// monitor takes results off the output queue and compares every field.
// The run steps through several set sizes, including the clamped extremes,
// and through three idling patterns plus one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxBits    = 1024;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  typedef struct {
    logic [bsc_pkg::WordBits-1:0] a;
    logic [bsc_pkg::WordBits-1:0] b;
    logic [bsc_pkg::SizeW-1:0]    start_bit;
  } word_pair_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           set_bits_we_i = 1'b0;
  logic [bsc_pkg::SizeW-1:0]      set_bits_i    = '0;
  logic                           push          = 1'b0;
  logic                           full;
  logic [bsc_pkg::WordBits-1:0]   word_a_i      = '0;
  logic [bsc_pkg::WordBits-1:0]   word_b_i      = '0;
  logic [bsc_pkg::SizeW-1:0]      search_from_i = '0;
  logic                           empty;
  logic                           pop           = 1'b0;
  logic [bsc_pkg::WordBits-1:0]   hash_a_o;
  logic [bsc_pkg::SizeW-1:0]      count_a_o;
  logic                           sets_equal_o;
  logic signed [1:0]              order_o;
  logic                           found_o;
  logic [bsc_pkg::IndexW-1:0]     found_index_o;

  word_pair_t                     words_to_send[$];
  bsc_pkg::result_t               results_due[$];
  word_pair_t                     next_pair;

  int unsigned                    send_idle   = 0;
  int unsigned                    recv_idle   = 0;
  int unsigned                    hold_left   = 0;
  int unsigned                    cycle_count = 0;
  int unsigned                    fault_count = 0;

  // scan model state
  logic [bsc_pkg::SizeW-1:0]      size_cfg = 11'd64;
  logic [bsc_pkg::WordPosW-1:0]   word_pos = '0;
  logic [bsc_pkg::WordBits-1:0]   acc_hash = '0;
  logic [bsc_pkg::SizeW-1:0]      acc_ones = '0;
  logic                           ord_known = 1'b0;
  logic signed [1:0]              ord_val = bsc_pkg::OrderNone;
  logic [bsc_pkg::SizeW-1:0]      start_pos = '0;
  logic                           hit = 1'b0;
  logic [bsc_pkg::IndexW-1:0]     hit_idx = '0;

  bitset_scan_compare_unit #(
    .MAX_BITS(MaxBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_bits_we_i (set_bits_we_i),
    .set_bits_i    (set_bits_i),
    .push          (push),
    .full          (full),
    .word_a_i      (word_a_i),
    .word_b_i      (word_b_i),
    .search_from_i (search_from_i),
    .empty         (empty),
    .pop           (pop),
    .hash_a_o      (hash_a_o),
    .count_a_o     (count_a_o),
    .sets_equal_o  (sets_equal_o),
    .order_o       (order_o),
    .found_o       (found_o),
    .found_index_o (found_index_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic fold_word(input logic [bsc_pkg::WordBits-1:0] wa,
                           input logic [bsc_pkg::WordBits-1:0] wb,
                           input logic [bsc_pkg::SizeW-1:0] from);
    int unsigned                  size;
    int unsigned                  base;
    int                           first;
    logic [bsc_pkg::WordBits-1:0] mask;
    logic [bsc_pkg::WordBits-1:0] a;
    logic [bsc_pkg::WordBits-1:0] b;
    logic [bsc_pkg::WordBits-1:0] d;
    logic [bsc_pkg::WordBits-1:0] low;
    logic [bsc_pkg::WordBits-1:0] cand;
    bsc_pkg::result_t             r;
    size = size_cfg;
    if (size < 1) size = 1;
    if (size > MaxBits) size = MaxBits;
    if (word_pos == 0) begin
      acc_hash  = '0;
      acc_ones  = '0;
      ord_known = 1'b0;
      ord_val   = bsc_pkg::OrderNone;
      hit       = 1'b0;
      hit_idx   = '0;
      start_pos = from;
    end
    base = word_pos * bsc_pkg::WordBits;
    if (base >= size) mask = '0;
    else if (size - base >= bsc_pkg::WordBits) mask = '1;
    else mask = (64'd1 << (size - base)) - 64'd1;
    a = wa & mask;
    b = wb & mask;
    acc_hash = acc_hash + a;
    acc_ones = acc_ones + bsc_pkg::SizeW'($countones(a));
    if (!ord_known) begin
      d = a ^ b;
      if (d != '0) begin
        low       = d & (~d + 64'd1);
        ord_val   = ((a & low) != '0) ? bsc_pkg::OrderAHigh : bsc_pkg::OrderBHigh;
        ord_known = 1'b1;
      end
    end
    if (!hit) begin
      if (start_pos >= base + bsc_pkg::WordBits) cand = '0;
      else if (start_pos > base) cand = a & ({bsc_pkg::WordBits{1'b1}} << (start_pos - base));
      else cand = a;
      if (cand != '0) begin
        first = 0;
        for (int k = bsc_pkg::WordBits - 1; k >= 0; k--) begin
          if (cand[k]) first = k;
        end
        hit     = 1'b1;
        hit_idx = bsc_pkg::IndexW'(base + first);
      end
    end
    if (base + bsc_pkg::WordBits < size) begin
      word_pos = word_pos + 1'b1;
    end else begin
      word_pos      = '0;
      r.hash_a      = acc_hash;
      r.count_a     = acc_ones;
      r.sets_equal  = !ord_known;
      r.order       = ord_known ? ord_val : bsc_pkg::OrderNone;
      r.found       = hit;
      r.found_index = hit ? hit_idx : '0;
      results_due.push_back(r);
    end
  endtask

  // driver: the word on the ports stays until its transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) fold_word(word_a_i, word_b_i, search_from_i);
      if (!push || !full) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_pair     = words_to_send.pop_front();
          push          <= 1'b1;
          word_a_i      <= next_pair.a;
          word_b_i      <= next_pair.b;
          search_from_i <= next_pair.start_bit;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input logic [bsc_pkg::WordBits-1:0] want,
                        input logic [bsc_pkg::WordBits-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fault_count++;
    end
  endtask

  task automatic check_result();
    bsc_pkg::result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: result with none expected, actual hash %h count %0d", $time,
               hash_a_o, count_a_o);
      fault_count++;
    end else begin
      want = results_due.pop_front();
      report("hash_a", want.hash_a, hash_a_o);
      report("count_a", bsc_pkg::WordBits'(want.count_a), bsc_pkg::WordBits'(count_a_o));
      report("sets_equal", bsc_pkg::WordBits'(want.sets_equal),
             bsc_pkg::WordBits'(sets_equal_o));
      report("order", bsc_pkg::WordBits'(unsigned'(want.order)),
             bsc_pkg::WordBits'(unsigned'(order_o)));
      report("found", bsc_pkg::WordBits'(want.found), bsc_pkg::WordBits'(found_o));
      report("found_index", bsc_pkg::WordBits'(want.found_index),
             bsc_pkg::WordBits'(found_index_o));
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL bitset_scan_compare_unit");
      $finish;
    end
  end

  task automatic add_item(input logic [bsc_pkg::WordBits-1:0] a,
                          input logic [bsc_pkg::WordBits-1:0] b,
                          input logic [bsc_pkg::SizeW-1:0] from);
    word_pair_t p;
    p.a         = a;
    p.b         = b;
    p.start_bit = from;
    words_to_send.push_back(p);
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (words_to_send.size() != 0 || push || results_due.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [bsc_pkg::SizeW-1:0] v);
    @(posedge clk_i);
    set_bits_we_i <= 1'b1;
    set_bits_i    <= v;
    @(posedge clk_i);
    set_bits_we_i <= 1'b0;
    size_cfg      = v;
    @(negedge clk_i);
  endtask

  function automatic logic [bsc_pkg::WordBits-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3, 4:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(input logic [bsc_pkg::SizeW-1:0] size_v, input int n_items,
                              input int unsigned s_idle, input int unsigned r_idle,
                              input int unsigned hold);
    int unsigned                  eff;
    int unsigned                  words;
    int unsigned                  shape;
    int unsigned                  flip_w;
    int unsigned                  flip_b;
    int                           left;
    logic [bsc_pkg::SizeW-1:0]    from;
    logic [bsc_pkg::WordBits-1:0] a;
    logic [bsc_pkg::WordBits-1:0] b;
    settle();
    write_size(size_v);
    eff       = (size_v == 0) ? 1 : (size_v > MaxBits) ? MaxBits : size_v;
    words     = (eff + bsc_pkg::WordBits - 1) / bsc_pkg::WordBits;
    send_idle = s_idle;
    recv_idle = r_idle;
    hold_left = hold;
    left      = n_items;
    while (left > 0) begin
      shape  = $urandom_range(3);
      flip_w = $urandom_range(words - 1);
      flip_b = $urandom_range(63);
      case ($urandom_range(4))
        0:       from = '0;
        1:       from = bsc_pkg::SizeW'(eff - 1);
        2:       from = bsc_pkg::SizeW'($urandom_range(2047));
        default: from = bsc_pkg::SizeW'($urandom_range(eff - 1));
      endcase
      for (int w = 0; w < words && left > 0; w++) begin
        a = pick_word();
        case (shape)
          0:       b = a;
          1:       b = (w == flip_w) ? a ^ (64'd1 << flip_b) : a;
          2:       b = pick_word();
          default: b = a ^ (pick_word() & pick_word() & pick_word());
        endcase
        add_item(a, b, (w == 0) ? from : bsc_pkg::SizeW'($urandom));
        left--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset size, one word per set
    add_item('0, '0, 11'd0);
    add_item('1, '1, 11'd0);
    add_item(64'd1 << 63, '0, 11'd63);
    add_item('0, 64'd1, 11'd5);
    add_item(64'h408, 64'h8, 11'd64);
    add_item('1, '0, 11'd2047);

    // size 0 clamps to one bit
    settle();
    write_size(11'd0);
    add_item('1, 64'h2, 11'd0);
    add_item(64'h2, '0, 11'd1);

    // partial final word, tail bits ignored
    settle();
    write_size(11'd100);
    add_item(64'hFF, 64'hFF, 11'd70);
    add_item((64'd1 << 16) | (64'd1 << 40), (64'd1 << 16) | (64'd1 << 40) | (64'd1 << 35),
             11'd0);
    add_item(64'hDEAD_BEEF_0123_4567, 64'hDEAD_BEEF_0123_4567, 11'd99);
    add_item(64'd1 << 35, 64'd1 << 36, 11'd0);

    // size shrinks mid-set, next word falls outside and closes the set
    settle();
    write_size(11'd200);
    add_item(64'hF0F0_0000_1234_0000, 64'hF0F0_0000_1234_0001, 11'd150);
    settle();
    write_size(11'd64);
    add_item('1, '0, 11'd0);

    random_phase(11'd64,   100, 14, 49, 0);
    random_phase(11'd130,   90, 14, 49, 0);
    random_phase(11'd1,     70, 14, 49, 0);
    random_phase(11'd1024,  48, 49, 14, 0);
    random_phase(11'd2047,  32, 49, 14, 0);
    random_phase(11'd37,    70, 49, 14, 0);
    random_phase(11'd64,   100,  0,  0, 200);
    random_phase(11'd300,   80,  0,  0, 0);
    random_phase(11'd0,     30,  0,  0, 0);

    settle();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("PASS bitset_scan_compare_unit");
    end else begin
      $display("FAIL bitset_scan_compare_unit");
    end
    $finish;
  end

endmodule
